// ===== hw/rtl/mfmte_pkg.sv =====
// ----------------------------------------------------------------------------
// mfmte_pkg
// Shared constants for the MFM track encoder: track geometry, sync and fill
// patterns, and request operation codes.
// ----------------------------------------------------------------------------
package mfmte_pkg;

  localparam int SECTORS   = 11;
  localparam int GAP_WORDS = 416;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_WORDS = 544;

  localparam logic [15:0] SYNC_WORD = 16'h4489;
  localparam logic [15:0] FILL_WORD = 16'haaaa;
  localparam logic [31:0] FILL_LONG = 32'haaaaaaaa;
  localparam logic [31:0] BIT_MASK  = 32'h55555555;
  localparam logic [7:0]  FILL_BYTE = 8'haa;
  localparam logic [7:0]  MASK_BYTE = 8'h55;
  localparam logic [7:0]  INFO_TAG  = 8'hff;

  // first word of each region inside a sector
  localparam logic [9:0] W_SYNC     = 10'd2;
  localparam logic [9:0] W_INFO     = 10'd4;
  localparam logic [9:0] W_INFO_EV  = 10'd6;
  localparam logic [9:0] W_LABEL    = 10'd8;
  localparam logic [9:0] W_HSUM     = 10'd24;
  localparam logic [9:0] W_HSUM_EV  = 10'd26;
  localparam logic [9:0] W_DSUM     = 10'd28;
  localparam logic [9:0] W_DSUM_EV  = 10'd30;
  localparam logic [9:0] W_DATA     = 10'd32;
  localparam logic [9:0] W_DATA_EV  = 10'd288;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

endpackage

// ===== hw/rtl/mfm_track_encoder.sv =====
// ----------------------------------------------------------------------------
// mfm_track_encoder
// Loads a 512-byte sector into a buffer with a running data checksum, then
// emits its 544 encoded track words one per fetch, closing the track with gap
// fill after the last sector.
// ----------------------------------------------------------------------------
// A load request (operation 0) is taken and busy stays low, so loads can
// follow back to back. A fetch request (operation 1) raises busy for one
// cycle while the sector buffer is read (synchronous read); the result
// appears on the cycle after acceptance, marked by done for exactly one
// cycle, and no new fetch is taken while busy is high. The receiver cannot
// stall: done must be sampled in that cycle. A fetch before the sector is
// fully loaded returns status 1 with a zero word. Loads made while a sector
// is being emitted or during the gap are dropped.
module mfm_track_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  track_number,
  output logic        done,
  output logic [15:0] mfm_word,
  output logic        last_of_sector,
  output logic        last_of_track,
  output logic        status
);
  import mfmte_pkg::*;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_EMIT,
    PH_GAP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_ODD,
    KIND_EVEN
  } kind_t;

  phase_t      phase;
  logic [9:0]  bytes_loaded;
  logic [9:0]  word_position;
  logic [4:0]  sector_index;
  logic [9:0]  gap_position;
  logic [31:0] data_sum;
  logic [7:0]  track_latch;

  kind_t       out_kind;
  logic [15:0] out_fixed;
  logic        out_los;
  logic        out_lot;
  logic        out_status;

  // sector buffer split by byte parity: even byte of a pair in hi, odd in lo
  logic [7:0]  mem_hi [256];
  logic [7:0]  mem_lo [256];
  logic [7:0]  rd_hi;
  logic [7:0]  rd_lo;
  logic [7:0]  rd_addr;

  logic        load_accept;
  logic        fetch_accept;
  logic [7:0]  sum_lane;
  logic [31:0] sum_next;
  logic [4:0]  sector_next;

  logic [7:0]  remaining;
  logic [31:0] info;
  logic [31:0] info_odd;
  logic [31:0] info_even;
  logic [31:0] hsum;
  logic [31:0] long_sel;
  logic [15:0] fixed_word;

  logic [7:0]  byte_hi;
  logic [7:0]  byte_lo;

  assign load_accept  = start && !busy && (operation == OP_LOAD) &&
                        (phase == PH_LOADING) && !bytes_loaded[9];
  assign fetch_accept = start && !busy && (operation == OP_FETCH);

  assign sum_lane    = ((data_byte >> 1) ^ data_byte) & MASK_BYTE;
  assign sum_next    = data_sum ^ ({24'b0, sum_lane} << {~bytes_loaded[1:0], 3'b000});
  assign sector_next = sector_index + 5'd1;
  assign rd_addr     = 8'(word_position - W_DATA);

  // non-data words of a sector
  assign remaining = 8'(SECTORS) - {3'b000, sector_index};
  assign info      = {INFO_TAG, track_latch, 3'b000, sector_index, remaining};
  assign info_odd  = (info >> 1) & BIT_MASK;
  assign info_even = info & BIT_MASK;
  assign hsum      = info_odd ^ info_even;

  always_comb begin
    long_sel = {FILL_WORD, FILL_WORD};
    priority if (word_position < W_SYNC) begin
      long_sel = {FILL_WORD, FILL_WORD};
    end else if (word_position < W_INFO) begin
      long_sel = {SYNC_WORD, SYNC_WORD};
    end else if (word_position < W_INFO_EV) begin
      long_sel = info_odd;
    end else if (word_position < W_LABEL) begin
      long_sel = info_even;
    end else if (word_position < W_HSUM) begin
      long_sel = {FILL_WORD, FILL_WORD};
    end else if (word_position < W_HSUM_EV) begin
      long_sel = ((hsum >> 1) & BIT_MASK) | FILL_LONG;
    end else if (word_position < W_DSUM) begin
      long_sel = (hsum & BIT_MASK) | FILL_LONG;
    end else if (word_position < W_DSUM_EV) begin
      long_sel = ((data_sum >> 1) & BIT_MASK) | FILL_LONG;
    end else begin
      long_sel = (data_sum & BIT_MASK) | FILL_LONG;
    end
    fixed_word = word_position[0] ? long_sel[15:0] : long_sel[31:16];
  end

  always_ff @(posedge clk) begin
    if (load_accept) begin
      if (bytes_loaded[0]) begin
        mem_lo[bytes_loaded[8:1]] <= data_byte;
      end else begin
        mem_hi[bytes_loaded[8:1]] <= data_byte;
      end
    end
    rd_hi <= mem_hi[rd_addr];
    rd_lo <= mem_lo[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LOADING;
      bytes_loaded  <= '0;
      word_position <= '0;
      sector_index  <= '0;
      gap_position  <= '0;
      data_sum      <= '0;
      track_latch   <= '0;
      busy          <= 1'b0;
    end else begin
      busy <= fetch_accept;
      if (load_accept) begin
        data_sum     <= sum_next;
        bytes_loaded <= bytes_loaded + 10'd1;
        if (bytes_loaded == 10'(SECTOR_BYTES - 1)) begin
          phase         <= PH_EMIT;
          word_position <= '0;
        end
      end
      if (fetch_accept) begin
        unique case (phase)
          PH_EMIT: begin
            out_lot    <= 1'b0;
            out_status <= STATUS_OK;
            out_fixed  <= fixed_word;
            if (sector_index == 5'd0 && word_position == 10'd0) begin
              track_latch <= track_number;
            end
            if (word_position >= W_DATA_EV) begin
              out_kind <= KIND_EVEN;
            end else if (word_position >= W_DATA) begin
              out_kind <= KIND_ODD;
            end else begin
              out_kind <= KIND_FIXED;
            end
            if (word_position == 10'(SECTOR_WORDS - 1)) begin
              out_los       <= 1'b1;
              word_position <= '0;
              bytes_loaded  <= '0;
              data_sum      <= '0;
              sector_index  <= sector_next;
              if (sector_next >= 5'(SECTORS)) begin
                phase        <= PH_GAP;
                gap_position <= '0;
              end else begin
                phase <= PH_LOADING;
              end
            end else begin
              out_los       <= 1'b0;
              word_position <= word_position + 10'd1;
            end
          end
          PH_GAP: begin
            out_los    <= 1'b0;
            out_status <= STATUS_OK;
            out_kind   <= KIND_FIXED;
            out_fixed  <= FILL_WORD;
            if (gap_position == 10'(GAP_WORDS - 1)) begin
              out_lot      <= 1'b1;
              gap_position <= '0;
              sector_index <= '0;
              phase        <= PH_LOADING;
            end else begin
              out_lot      <= 1'b0;
              gap_position <= gap_position + 10'd1;
            end
          end
          default: begin
            out_los    <= 1'b0;
            out_lot    <= 1'b0;
            out_kind   <= KIND_FIXED;
            out_fixed  <= '0;
            out_status <= STATUS_NOT_READY;
          end
        endcase
      end
    end
  end

  always_comb begin
    byte_hi  = FILL_BYTE | (rd_hi & MASK_BYTE);
    byte_lo  = FILL_BYTE | (rd_lo & MASK_BYTE);
    mfm_word = out_fixed;
    unique case (out_kind)
      KIND_ODD: begin
        byte_hi  = FILL_BYTE | ((rd_hi >> 1) & MASK_BYTE);
        byte_lo  = FILL_BYTE | ((rd_lo >> 1) & MASK_BYTE);
        mfm_word = {byte_hi, byte_lo};
      end
      KIND_EVEN: begin
        mfm_word = {byte_hi, byte_lo};
      end
      default: begin
        mfm_word = out_fixed;
      end
    endcase
  end

  assign done           = busy;
  assign last_of_sector = out_los;
  assign last_of_track  = out_lot;
  assign status         = out_status;

  a_fetch_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_FETCH) |=> done)
    else $error("fetch request without a result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_LOAD) |=> !done)
    else $error("load request produced a result");

  a_track_end: assert property (@(posedge clk) disable iff (rst)
    (done && last_of_track) |-> (!last_of_sector && status == STATUS_OK))
    else $error("track end flagged with sector end or not-ready status");

  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT) |-> (bytes_loaded == 10'(SECTOR_BYTES)))
    else $error("emitting a sector that is not fully loaded");

  a_gap_sector: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_GAP) |-> (sector_index == 5'(SECTORS) && bytes_loaded == 10'd0))
    else $error("gap entered before the last sector");

endmodule
